@@ sv/spibs_pkg.sv @@
// spibs_pkg: widths, codes and divider-setting tables for the serial-clock divider search
// shared by spibs_div, spi_baud_setting_search and spibs_checker; no dependencies
package spibs_pkg;

  // field widths
  localparam int CLK_W      = 29;
  localparam int TARGET_W   = 31;
  localparam int RATE_W     = 26;
  localparam int CEIL_W     = 28;
  localparam int RES_W      = 34;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;

  // shared divider widths
  localparam int NUM_W = CLK_W + 1;
  localparam int DEN_W = 20;
  localparam int CNT_W = $clog2(NUM_W);

  // setting index: double-rate bit, prescaler code, scaler code
  localparam int IDX_W = 7;
  localparam logic [IDX_W-1:0] IDX_LAST = 7'd127;

  localparam logic [CLK_W-1:0] CLOCK_RESET = 29'd100000000;
  localparam logic [DEN_W-1:0] CEIL_DEN    = 20'd3;

  // scaler codes whose values differ from the plain power of two 1 << code
  localparam logic [3:0] SCL_TWO  = 4'd0;
  localparam logic [3:0] SCL_FOUR = 4'd1;
  localparam logic [3:0] SCL_SIX  = 4'd2;

  localparam logic [2:0] PRESC_VAL [4] = '{3'd2, 3'd3, 3'd5, 3'd7};

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // divisor 4 * prescale * scaler of one setting
  function automatic logic [DEN_W-1:0] setting_den(logic [1:0] pcode, logic [3:0] scode);
    logic [15:0]      scal;
    logic [DEN_W-1:0] prod;
    case (scode)
      SCL_TWO:  scal = 16'd2;
      SCL_FOUR: scal = 16'd4;
      SCL_SIX:  scal = 16'd6;
      default:  scal = 16'd1 << scode;
    endcase
    prod = DEN_W'(PRESC_VAL[pcode]) * DEN_W'(scal);
    return {prod[DEN_W-3:0], 2'b00};
  endfunction

endpackage

@@ sv/spibs_div.sv @@
// spibs_div: radix-2 restoring divider, one quotient bit per cycle
// depends on spibs_pkg for widths and the request/response structs
module spibs_div import spibs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den_r;

  // one shift-subtract step
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy  <= 1'b1;
          cnt   <= '0;
          rem   <= '0;
          quo   <= req.num;
          den_r <= req.den;
        end
      end else begin
        rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quot: quo};

endmodule

@@ sv/spi_baud_setting_search.sv @@
// spi_baud_setting_search: top level of the serial-clock divider setting search
// depends on spibs_pkg and spibs_div
//
// Usage:
//   s_* channel takes one request; s_tdata[30:0] is the requested rate in hertz.
//   m_* channel returns one result per request (fields in the m_tdata comment).
//   cfg_we/cfg_wdata write the module clock frequency in hertz (reset 100000000);
//   write it only while no request is in flight.
// Timing:
//   a request runs one division for the clock/3 ceiling and then one for each
//   of the 128 settings, every division on the one shared radix-2 divider.
//   s_tready is high only while the sequencer is idle, so one request is worked
//   at a time. The result sits in an output register; a new request is taken
//   while it waits, and the next result holds back until the receiver takes it.
// Reset:
//   rst (synchronous) returns the sequencer to idle, drops m_tvalid and loads
//   the reset clock frequency.
module spi_baud_setting_search import spibs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CLK_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] target_rate
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [0] found, [2:1] prescale_code,
                                            // [6:3] scaler_code, [7] double_rate,
                                            // [33:8] achieved_rate
);

  typedef enum logic [1:0] {S_IDLE, S_CEIL, S_CAND, S_OUT} state_t;

  state_t              state;
  logic [CLK_W-1:0]    clock_hz;
  logic [TARGET_W-1:0] target;
  logic [CEIL_W-1:0]   ceiling;
  logic [IDX_W-1:0]    idx;
  logic                have;
  logic [RATE_W-1:0]   best_rate;
  logic [1:0]          best_p;
  logic [3:0]          best_s;
  logic                best_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  spibs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_wdata;
    end
  end

  // next setting operands
  logic [IDX_W-1:0] idx_next;
  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;

  assign idx_next = idx + 1'b1;
  assign num_next = idx_next[6] ? {clock_hz, 1'b0} : {1'b0, clock_hz};
  assign den_next = setting_den(idx_next[5:4], idx_next[3:0]);

  // candidate check: within ceiling and request, strictly better than best
  logic take;
  assign take = (div_rsp.quot <= {2'b00, ceiling})
             && ({1'b0, div_rsp.quot} <= target)
             && (!have || (div_rsp.quot > {4'b0000, best_rate}));

  // divider launch: ceiling on a request, then each setting after the last one ends
  logic launch;
  assign launch = (state == S_IDLE && s_tvalid)
               || (state == S_CEIL && div_rsp.done)
               || (state == S_CAND && div_rsp.done && idx != IDX_LAST);

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      div_req.start <= 1'b0;
      have          <= 1'b0;
    end else begin
      div_req.start <= launch;
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            target        <= s_tdata[TARGET_W-1:0];
            have          <= 1'b0;
            best_rate     <= '0;
            best_p        <= '0;
            best_s        <= '0;
            best_d        <= 1'b0;
            div_req.num   <= {1'b0, clock_hz};
            div_req.den   <= CEIL_DEN;
            state         <= S_CEIL;
          end
        end
        S_CEIL: begin
          if (div_rsp.done) begin
            ceiling       <= div_rsp.quot[CEIL_W-1:0];
            idx           <= '0;
            div_req.num   <= {1'b0, clock_hz};
            div_req.den   <= setting_den(2'd0, 4'd0);
            state         <= S_CAND;
          end
        end
        S_CAND: begin
          if (div_rsp.done) begin
            if (take) begin
              have      <= 1'b1;
              best_rate <= div_rsp.quot[RATE_W-1:0];
              best_d    <= idx[6];
              best_p    <= idx[5:4];
              best_s    <= idx[3:0];
            end
            if (idx == IDX_LAST) begin
              state <= S_OUT;
            end else begin
              idx           <= idx_next;
              div_req.num   <= num_next;
              div_req.den   <= den_next;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_TDATA_W-RES_W){1'b0}}, best_rate, best_d, best_s, best_p, have};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/spibs_checker.sv @@
// spibs_checker: port-level assertions for spi_baud_setting_search, bound to the top level
// depends on spibs_pkg for the result layout
module spibs_checker import spibs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed or dropped while stalled");

  // the search is busy right after a request transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a search is running");

  // no setting found gives an all-zero result
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("result fields set without found");

  // padding above the result stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_TDATA_W-1:RES_W] == '0))
    else $error("padding bits set");

  // reset drops the result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind spi_baud_setting_search spibs_checker u_spibs_checker (.*);
